>>> hw/rtl/layered_earth_density_eval_unit_macros.svh
// Assertion macros used by the RTL of the layered earth density evaluator.
// Each macro takes a label, the clock, the active-low reset, the two sides of
// the implication and a message string.
`ifndef LAYERED_EARTH_DENSITY_EVAL_UNIT_MACROS_SVH
`define LAYERED_EARTH_DENSITY_EVAL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LEDU_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define LEDU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LEDU_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define LEDU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ledu_pkg.sv
package ledu_pkg;

    localparam int unsigned EARTH_RADIUS_KM = 6371;
    localparam int unsigned NUM_LAYERS      = 10;
    localparam int unsigned LAYER_IDX_W     = $clog2(NUM_LAYERS);

    // Earth radius in tenths of a km.
    localparam logic [63:0] RAD10 = 64'(EARTH_RADIUS_KM) * 64'd10;

    // Smallest Q1.16 radius that is no longer inside layer i:
    // r < ceil(B10 * 2^16 / RAD10) is the same test as r * RAD10 < B10 * 2^16.
    localparam logic [16:0] LAYER_TOP [NUM_LAYERS-1] = '{
        17'((64'd12215 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd34800 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd57010 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd57710 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd59710 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd61510 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd63466 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd63560 * 64'd65536 + RAD10 - 64'd1) / RAD10),
        17'((64'd63680 * 64'd65536 + RAD10 - 64'd1) / RAD10)
    };

    typedef logic signed [17:0] coef_val_t;

    // Polynomial coefficients in units of 1e-4, constant term first.
    typedef struct packed {
        coef_val_t c0;
        coef_val_t c1;
        coef_val_t c2;
        coef_val_t c3;
    } coef_t;

    localparam coef_t LAYER_COEF [NUM_LAYERS] = '{
        '{ 18'sd130885,  18'sd0,      -18'sd88301,  18'sd0     },
        '{ 18'sd125815, -18'sd12638,  -18'sd36426, -18'sd55281 },
        '{ 18'sd79565,  -18'sd64761,   18'sd55283, -18'sd30807 },
        '{ 18'sd53197,  -18'sd14836,   18'sd0,      18'sd0     },
        '{ 18'sd112494, -18'sd80298,   18'sd0,      18'sd0     },
        '{ 18'sd71089,  -18'sd38045,   18'sd0,      18'sd0     },
        '{ 18'sd26910,   18'sd6924,    18'sd0,      18'sd0     },
        '{ 18'sd29000,   18'sd0,       18'sd0,      18'sd0     },
        '{ 18'sd26000,   18'sd0,       18'sd0,      18'sd0     },
        '{ 18'sd10200,   18'sd0,       18'sd0,      18'sd0     }
    };

    // Electron density uses the outer factor when r * 1000 > 546 * 2^16.
    localparam logic [15:0] HI_BAND_LIMIT = 16'((64'd546 * 64'd65536) / 64'd1000);
    localparam logic [8:0]  FACTOR_OUTER  = 9'd497;
    localparam logic [8:0]  FACTOR_INNER  = 9'd468;

    // The polynomial sum is divided by 1e4 * 2^16 = 625 * 2^20 with rounding.
    localparam logic [51:0] POLY_ROUND = 52'd327680000;
    localparam int unsigned POLY_SHIFT = 20;
    localparam logic [31:0] DIV_A      = 32'd625;
    localparam int unsigned RECIP_A_SH = 40;
    localparam logic [30:0] RECIP_A    = 31'((64'd1 << RECIP_A_SH) / 64'd625);

    // The scaled electron density is divided by 1000 = 125 * 8 with rounding.
    localparam logic [30:0] SCALE_ROUND = 31'd500;
    localparam logic [28:0] DIV_B       = 29'd125;
    localparam int unsigned RECIP_B_SH  = 36;
    localparam logic [29:0] RECIP_B     = 30'((64'd1 << RECIP_B_SH) / 64'd125);

    localparam logic [19:0] DENS_MAX  = 20'hFFFFF;
    // Largest density the layer table can give: the center of the inner core.
    localparam logic [19:0] DENS_PEAK = 20'((64'd130885 * 64'd65536 + 64'd5000) / 64'd10000);

    typedef struct packed {
        logic  outside;
        logic  hi_band;
        coef_t coef;
    } sel_t;

    typedef struct packed {
        logic mode;
        logic outside;
        logic hi_band;
    } flags_t;

endpackage

>>> hw/rtl/ledu_layer_sel.sv
module ledu_layer_sel (
    input  logic [16:0]     radius_fraction,
    output ledu_pkg::sel_t  sel
);

    logic [ledu_pkg::LAYER_IDX_W-1:0] idx;

    // Thresholds rise with the layer, so the lowest one above the radius wins.
    always_comb begin
        idx = ledu_pkg::LAYER_IDX_W'(ledu_pkg::NUM_LAYERS - 1);
        for (int i = ledu_pkg::NUM_LAYERS - 2; i >= 0; i--) begin
            if (radius_fraction < ledu_pkg::LAYER_TOP[i]) begin
                idx = ledu_pkg::LAYER_IDX_W'(i);
            end
        end
    end

    assign sel.outside = radius_fraction[16];
    assign sel.hi_band = (radius_fraction[15:0] > ledu_pkg::HI_BAND_LIMIT);
    assign sel.coef    = ledu_pkg::LAYER_COEF[idx];

endmodule

>>> hw/rtl/layered_earth_density_eval_unit.sv
// Layered earth density evaluator.
// Input channel (s_): each item carries a radius as a fraction of the earth
// radius in unsigned Q1.16 on s_tdata, and on s_tuser a mode bit that selects
// mass density (0) or electron density (1). Output channel (m_): one item per
// input item, the density in unsigned Q4.16 g/cm3 on m_tdata, saturating.
// Radii of 1.0 and above give zero density.
// The block is a nine-stage pipeline: layer lookup and square, cube and the
// low-order products, the cubic product, the sum and rounding shift, two
// stages for the reciprocal divide by 625, the electron scaling, and two
// stages for the divide by 125 that end in the output register.
// One item is accepted per cycle while the receiver does not stall, since
// every stage takes a new item at each advance.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; empty stages keep filling while the output is empty.
// Reset (aresetn low at a rising edge) empties every stage; no item is lost
// or repeated across a stall.
`include "layered_earth_density_eval_unit_macros.svh"

module layered_earth_density_eval_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [16:0] radius_fraction, [23:17] zero fill
    input  logic [0:0]  s_tuser,    // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [19:0] density, [23:20] zero fill
);

    // One enable moves every stage. A stage advances whenever the output
    // register is empty or being read, so bubbles never block new items.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: layer lookup and r squared.
    ledu_pkg::sel_t sel;

    ledu_layer_sel u_sel (
        .radius_fraction (s_tdata[16:0]),
        .sel             (sel)
    );

    logic                 v1_reg;
    logic [15:0]          r1_reg;
    logic [31:0]          rsq1_reg;
    ledu_pkg::coef_t      coef1_reg;
    ledu_pkg::flags_t     flags1_reg;
    logic [31:0]          rsq1_next;

    assign rsq1_next = 32'(s_tdata[15:0]) * 32'(s_tdata[15:0]);

    // Stage 2: r cubed (scaled down by 2^16) and the linear and square terms.
    logic                 v2_reg;
    logic [31:0]          rcube2_reg;
    logic signed [34:0]   t1_2_reg;
    logic signed [50:0]   t2_2_reg;
    ledu_pkg::coef_val_t  c0_2_reg;
    ledu_pkg::coef_val_t  c3_2_reg;
    ledu_pkg::flags_t     flags2_reg;
    logic [47:0]          rcube_full;
    logic signed [34:0]   t1_2_next;
    logic signed [50:0]   t2_2_next;

    assign rcube_full = 48'(rsq1_reg) * 48'(r1_reg);
    assign t1_2_next  = 35'(coef1_reg.c1) * 35'($signed({1'b0, r1_reg}));
    assign t2_2_next  = 51'(coef1_reg.c2) * 51'($signed({1'b0, rsq1_reg}));

    // Stage 3: cubic term, and the other three terms summed at 2^-32 scale.
    logic                 v3_reg;
    logic signed [51:0]   part3_reg;
    logic signed [50:0]   t3_3_reg;
    ledu_pkg::flags_t     flags3_reg;
    logic signed [51:0]   part3_next;
    logic signed [50:0]   t3_3_next;

    assign t3_3_next  = 51'(c3_2_reg) * 51'($signed({1'b0, rcube2_reg}));
    assign part3_next = 52'($signed({c0_2_reg, 32'd0}))
                      + 52'($signed({t1_2_reg, 16'd0}))
                      + 52'(t2_2_reg);

    // Stage 4: full sum, clamp at zero, add half and drop the 2^20 part.
    logic                 v4_reg;
    logic [30:0]          q1_4_reg;
    ledu_pkg::flags_t     flags4_reg;
    logic signed [51:0]   poly_sum;
    logic [51:0]          poly_rnd;

    assign poly_sum = part3_reg + 52'(t3_3_reg);
    assign poly_rnd = (poly_sum[51] ? 52'd0 : 52'(poly_sum)) + ledu_pkg::POLY_ROUND;

    // Stage 5: quotient estimate by 625 through a reciprocal multiply. The
    // estimate is the true quotient or one below it.
    logic                 v5_reg;
    logic [30:0]          q1_5_reg;
    logic [21:0]          qa5_reg;
    ledu_pkg::flags_t     flags5_reg;
    logic [61:0]          recip_a_prod;

    assign recip_a_prod = 62'(q1_4_reg) * 62'(ledu_pkg::RECIP_A);

    // Stage 6: correct the estimate; the result is the Q4.16 mass density.
    logic                 v6_reg;
    logic [21:0]          d6_reg;
    ledu_pkg::flags_t     flags6_reg;
    logic [31:0]          rem_a;

    assign rem_a = 32'(q1_5_reg) - 32'(qa5_reg) * ledu_pkg::DIV_A;

    // Stage 7: electron scaling by the band factor plus the rounding half.
    logic                 v7_reg;
    logic [30:0]          e7_reg;
    logic [21:0]          d7_reg;
    ledu_pkg::flags_t     flags7_reg;
    logic [8:0]           factor;

    assign factor = flags6_reg.hi_band ? ledu_pkg::FACTOR_OUTER : ledu_pkg::FACTOR_INNER;

    // Stage 8: divide by 8 by shifting, then estimate the quotient by 125.
    logic                 v8_reg;
    logic [27:0]          y8_reg;
    logic [20:0]          qb8_reg;
    logic [21:0]          d8_reg;
    ledu_pkg::flags_t     flags8_reg;
    logic [27:0]          y8_next;
    logic [57:0]          recip_b_prod;

    assign y8_next      = e7_reg[30:3];
    assign recip_b_prod = 58'(y8_next) * 58'(ledu_pkg::RECIP_B);

    // Stage 9: correct, pick the mode, saturate into the output register.
    logic                 v9_reg;
    logic [19:0]          dens_reg;
    logic [28:0]          rem_b;
    logic [21:0]          elec_dens;
    logic [21:0]          pick_dens;
    logic [19:0]          dens_next;

    assign rem_b     = 29'(y8_reg) - 29'(qb8_reg) * ledu_pkg::DIV_B;
    assign elec_dens = 22'(qb8_reg) + 22'(rem_b >= ledu_pkg::DIV_B);
    assign pick_dens = flags8_reg.outside ? 22'd0 :
                       (flags8_reg.mode ? elec_dens : d8_reg);
    assign dens_next = (pick_dens > 22'(ledu_pkg::DENS_MAX)) ? ledu_pkg::DENS_MAX
                                                             : pick_dens[19:0];

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // Data path registers; no reset needed.
    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg             <= s_tdata[15:0];
            rsq1_reg           <= rsq1_next;
            coef1_reg          <= sel.coef;
            flags1_reg.mode    <= s_tuser[0];
            flags1_reg.outside <= sel.outside;
            flags1_reg.hi_band <= sel.hi_band;

            rcube2_reg <= rcube_full[47:16];
            t1_2_reg   <= t1_2_next;
            t2_2_reg   <= t2_2_next;
            c0_2_reg   <= coef1_reg.c0;
            c3_2_reg   <= coef1_reg.c3;
            flags2_reg <= flags1_reg;

            part3_reg  <= part3_next;
            t3_3_reg   <= t3_3_next;
            flags3_reg <= flags2_reg;

            q1_4_reg   <= poly_rnd[ledu_pkg::POLY_SHIFT +: 31];
            flags4_reg <= flags3_reg;

            q1_5_reg   <= q1_4_reg;
            qa5_reg    <= recip_a_prod[ledu_pkg::RECIP_A_SH +: 22];
            flags5_reg <= flags4_reg;

            d6_reg     <= qa5_reg + 22'(rem_a >= ledu_pkg::DIV_A);
            flags6_reg <= flags5_reg;

            e7_reg     <= 31'(d6_reg) * 31'(factor) + ledu_pkg::SCALE_ROUND;
            d7_reg     <= d6_reg;
            flags7_reg <= flags6_reg;

            y8_reg     <= y8_next;
            qb8_reg    <= recip_b_prod[ledu_pkg::RECIP_B_SH +: 21];
            d8_reg     <= d7_reg;
            flags8_reg <= flags7_reg;

            dens_reg   <= dens_next;
        end
    end

    assign m_tvalid = v9_reg;
    assign m_tdata  = {4'd0, dens_reg};

    // The reciprocal estimates may fall short of the quotient by one at most.
    `LEDU_ASSERT_IMPLIES(a_div625_est, aclk, aresetn, v5_reg,
        rem_a < (ledu_pkg::DIV_A << 1), "divide by 625 estimate off by more than one")
    `LEDU_ASSERT_IMPLIES(a_div125_est, aclk, aresetn, v8_reg,
        rem_b < (ledu_pkg::DIV_B << 1), "divide by 125 estimate off by more than one")
    // No layer gives more than the density at the center of the inner core.
    `LEDU_ASSERT_IMPLIES(a_dens_peak, aclk, aresetn, m_tvalid,
        dens_reg <= ledu_pkg::DENS_PEAK, "density above the inner core peak")
    // An item in the last compute stage reaches the output on an advance.
    `LEDU_ASSERT_NEXT(a_last_stage_moves, aclk, aresetn, adv && v8_reg,
        m_tvalid, "item lost between the last stage and the output")

endmodule

>>> verif/layered_earth_density_eval_unit_test.sv
`default_nettype none

module layered_earth_density_eval_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode bit on s_tuser.
    localparam logic MODE_MASS     = 1'b0;
    localparam logic MODE_ELECTRON = 1'b1;

    localparam longint RADIUS_KM   = 6371;
    localparam int     NUM_SHELLS  = 10;
    // Index used in the coverage counters for radii of 1.0 and above.
    localparam int     SHELL_OUT   = NUM_SHELLS;
    localparam int     N_DIRECTED  = 20;
    localparam int     N_RANDOM    = 600;
    localparam int     N_TOTAL     = N_DIRECTED + N_RANDOM;
    // The last items run with both sides streaming at full rate.
    localparam int     N_CALM      = 80;
    // The pipeline is nine stages deep; give it a comfortable margin.
    localparam int     DRAIN_CYCLES = 24;

    // One row of the directed table. When has_value is set, the density in the
    // row is what the block must return; otherwise the predictor decides.
    typedef struct {
        logic [16:0] radius;
        logic        mode;
        logic        has_value;
        logic [19:0] density;
    } stim_row_t;

    // One density that is still owed by the block.
    typedef struct {
        logic [19:0] density;
        logic [16:0] radius;
        logic        mode;
    } density_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // [16:0] radius_fraction, [23:17] zero fill
    logic [0:0]  s_tuser  = '0;     // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [19:0] density, [23:20] zero fill

    // Upper layer boundaries in tenths of a km, innermost first. The outermost
    // layer needs no boundary since everything below 1.0 falls into it.
    longint shell_top_km10 [NUM_SHELLS-1] = '{
        12215, 34800, 57010, 57710, 59710, 61510, 63466, 63560, 63680
    };

    // First Q1.16 radius of each layer above the core. The random part aims a
    // share of its items a few codes to either side of these.
    int shell_first [NUM_SHELLS-1] = '{
        12566, 35798, 58644, 59365, 61422, 63273, 65286, 65382, 65506
    };

    // Directed items: the two ends of the radius range in both modes, the
    // crossing from inside to outside, the first radius of every layer, and
    // the two sides of the electron-factor switch near x = 0.546.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{17'd0,      MODE_MASS,     1'b1, 20'd857768},
        '{17'd0,      MODE_ELECTRON, 1'b1, 20'd401435},
        '{17'd65535,  MODE_MASS,     1'b0, 20'd0},
        '{17'd65535,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd65536,  MODE_MASS,     1'b1, 20'd0},
        '{17'd65536,  MODE_ELECTRON, 1'b1, 20'd0},
        '{17'd131071, MODE_MASS,     1'b1, 20'd0},
        '{17'd131071, MODE_ELECTRON, 1'b1, 20'd0},
        '{17'd12565,  MODE_MASS,     1'b0, 20'd0},
        '{17'd12566,  MODE_MASS,     1'b0, 20'd0},
        '{17'd35798,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd58644,  MODE_MASS,     1'b0, 20'd0},
        '{17'd59365,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd61422,  MODE_MASS,     1'b0, 20'd0},
        '{17'd63273,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd65286,  MODE_MASS,     1'b0, 20'd0},
        '{17'd65382,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd65506,  MODE_MASS,     1'b0, 20'd0},
        '{17'd35782,  MODE_ELECTRON, 1'b0, 20'd0},
        '{17'd35783,  MODE_ELECTRON, 1'b0, 20'd0}
    };

    density_rec_t density_q [$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int electron_sent = 0;
    int shell_hits [NUM_SHELLS+1];
    int stall_left    = 0;
    logic no_stall    = 1'b0;

    layered_earth_density_eval_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Density for one radius and mode. The layer is found with the exact
    // integer test r * R * 10 < B10 * 2^16, so no rounding of the boundaries
    // creeps in. The polynomial is summed in units of 1e-4 * 2^-32 and divided
    // down to Q4.16 with rounding half up; electron mode then applies 0.497
    // or 0.468, again rounding half up. The layer index comes back for
    // coverage, with SHELL_OUT for radii of 1.0 and above.
    function automatic logic [19:0] predict_density(input logic [16:0] r, input logic m,
                                                    output int shell);
        longint lhs, x, x2, x3, acc, d;
        longint c0, c1, c2, c3;
        shell = NUM_SHELLS - 1;
        lhs = longint'(r) * RADIUS_KM * 10;
        for (int i = NUM_SHELLS - 2; i >= 0; i--) begin
            if (lhs < shell_top_km10[i] * 65536) shell = i;
        end
        case (shell)
            0:       begin c0 = 130885; c1 = 0;      c2 = -88301; c3 = 0;      end
            1:       begin c0 = 125815; c1 = -12638; c2 = -36426; c3 = -55281; end
            2:       begin c0 = 79565;  c1 = -64761; c2 = 55283;  c3 = -30807; end
            3:       begin c0 = 53197;  c1 = -14836; c2 = 0;      c3 = 0;      end
            4:       begin c0 = 112494; c1 = -80298; c2 = 0;      c3 = 0;      end
            5:       begin c0 = 71089;  c1 = -38045; c2 = 0;      c3 = 0;      end
            6:       begin c0 = 26910;  c1 = 6924;   c2 = 0;      c3 = 0;      end
            7:       begin c0 = 29000;  c1 = 0;      c2 = 0;      c3 = 0;      end
            8:       begin c0 = 26000;  c1 = 0;      c2 = 0;      c3 = 0;      end
            default: begin c0 = 10200;  c1 = 0;      c2 = 0;      c3 = 0;      end
        endcase
        x   = longint'(r);
        x2  = x * x;
        x3  = (x2 * x) >> 16;
        acc = c0 * (longint'(1) << 32) + c1 * (x << 16) + c2 * x2 + c3 * x3;
        // A negative sum clamps to zero, although no layer reaches one.
        if (acc < 0) d = 0;
        else d = (acc + 64'd327680000) / 64'd655360000;
        if (r >= 17'd65536) begin
            d = 0;
            shell = SHELL_OUT;
        end else if (m == MODE_ELECTRON) begin
            if (x * 1000 > 546 * 65536) d = (d * 497 + 500) / 1000;
            else d = (d * 468 + 500) / 1000;
        end
        if (d > 1048575) d = 1048575;
        return d[19:0];
    endfunction

    // Receiving side: checks every density that leaves the block against the
    // oldest one owed, then decides whether to stall for the next cycle.
    // Stalls come in bursts and stop for the tail.
    always @(posedge aclk) begin : density_monitor
        density_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (density_q.size() == 0) begin
                $display("%0t: density 0x%05h arrived with none expected",
                         $time, m_tdata[19:0]);
                error_count++;
            end else begin
                want = density_q.pop_front();
                results_seen++;
                if (m_tdata[19:0] !== want.density) begin
                    $display("%0t: radius 0x%05h mode %0b: expected density 0x%05h, got 0x%05h",
                             $time, want.radius, want.mode, want.density, m_tdata[19:0]);
                    error_count++;
                end
            end
        end
        if (no_stall) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Sending side: the directed table first, then random radii. Each item
    // is held on the bus until the block takes it; its expected density is
    // queued at that same edge.
    initial begin : stimulus
        logic [16:0] r;
        logic        m;
        logic        has_value;
        logic [19:0] table_density;
        logic [19:0] want_density;
        int          shell;
        int          pick;
        int          near;
        int          reached;

        foreach (shell_hits[i]) shell_hits[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int idx = 0; idx < N_TOTAL; idx++) begin
            if (idx == N_TOTAL - N_CALM) no_stall <= 1'b1;
            if (idx < N_DIRECTED) begin
                r             = directed_rows[idx].radius;
                m             = directed_rows[idx].mode;
                has_value     = directed_rows[idx].has_value;
                table_density = directed_rows[idx].density;
            end else begin
                has_value     = 1'b0;
                table_density = '0;
                pick          = $urandom_range(0, 99);
                if (pick < 55) begin
                    // Anywhere inside the earth.
                    r = 17'($urandom_range(0, 65535));
                end else if (pick < 75) begin
                    // Just around a layer boundary.
                    near = shell_first[$urandom_range(0, NUM_SHELLS - 2)]
                           + int'($urandom_range(0, 6)) - 3;
                    r = 17'(near);
                end else if (pick < 90) begin
                    // Outside, where the density must be zero.
                    r = 17'($urandom_range(65536, 131071));
                end else begin
                    case ($urandom_range(0, 7))
                        0: r = 17'd0;
                        1: r = 17'd1;
                        2: r = 17'd65534;
                        3: r = 17'd65535;
                        4: r = 17'd65536;
                        5: r = 17'd131071;
                        6: r = 17'd35782;
                        default: r = 17'd35783;
                    endcase
                end
                m = ($urandom_range(0, 1) == 1) ? MODE_ELECTRON : MODE_MASS;
            end

            // Gaps on the sending side, in bursts, except in the tail.
            if (idx > 0 && idx < N_TOTAL - N_CALM && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end

            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, r};
            s_tuser  <= m;
            do @(posedge aclk); while (!s_tready);

            want_density = predict_density(r, m, shell);
            if (has_value) want_density = table_density;
            density_q.push_back('{density: want_density, radius: r, mode: m});
            shell_hits[shell]++;
            items_sent++;
            if (m == MODE_ELECTRON) electron_sent++;
        end
        s_tvalid <= 1'b0;

        // Wait for every owed density, then a little longer to catch strays.
        while (density_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        reached = 0;
        for (int i = 0; i < NUM_SHELLS; i++) if (shell_hits[i] != 0) reached++;
        $display("%0d items sent (%0d in electron mode), %0d densities checked, %0d errors",
                 items_sent, electron_sent, results_seen, error_count);
        $display("layers reached: %0d of %0d, radii at or beyond 1.0: %0d",
                 reached, NUM_SHELLS, shell_hits[SHELL_OUT]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run, in which every item waits behind a full
    // sender gap and a full receiver stall.
    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout with %0d densities outstanding", $time, density_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
